>>> src/sotp_pkg.sv
// sotp_pkg: shared types and constants for the SOME/IP-TP segmenter.
// No dependencies. Used by every module of the block.
package sotp_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic CFG_MAX_MSG = 1'b0;
    localparam logic CFG_MAX_SEG = 1'b1;

    localparam logic [31:0] MAX_MSG_RST    = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_SEG_RST    = 32'd1392;
    localparam logic [31:0] SINGLE_LEN_MAX = 32'd65519;
    localparam logic [31:0] SEG_SIZE_MAX   = 32'd65515;
    localparam logic [31:0] LEN_ADD_PLAIN  = 32'd8;
    localparam logic [31:0] LEN_ADD_TP     = 32'd12;
    localparam logic [7:0]  TP_FLAG        = 8'h20;
    localparam logic [4:0]  HDR_BYTES      = 5'd16;
    localparam logic [4:0]  TP_HDR_BYTES   = 5'd20;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_HDR     = 2'd1,
        KIND_PAYLOAD = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_TOO_LARGE = 2'd1,
        STAT_SEG_FAIL  = 2'd2
    } status_t;

    localparam logic [1:0] SEG_SINGLE      = 2'd0;
    localparam logic [1:0] SEG_FIRST       = 2'd1;
    localparam logic [1:0] SEG_CONSECUTIVE = 2'd2;
    localparam logic [1:0] SEG_LAST        = 2'd3;

    typedef enum logic [1:0] {
        JOB_STATUS   = 2'd0,
        JOB_HDR      = 2'd1,
        JOB_BYTE     = 2'd2,
        JOB_BYTE_HDR = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t   jk;
        status_t     stat;
        logic [7:0]  dbyte;
        logic        byte_eos;
        logic [1:0]  byte_type;
        logic [31:0] byte_off;
        logic [7:0]  seq;
        logic [63:0] h0;
        logic [31:0] h1;
        logic [31:0] hlen;
        logic [31:0] hword;
        logic        htp;
        logic        heos;
        logic [1:0]  htype;
        logic [31:0] hoff;
    } job_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [1:0]  seg_type;
        logic [31:0] seg_offset;
        logic [7:0]  seq_number;
        logic        end_of_segment;
        status_t     status;
        logic        last;
    } res_t;

endpackage

>>> src/sotp_front.sv
// sotp_front: accepts input transfers, tracks message and segment state,
// and issues one job per transfer that produces results. Depends on sotp_pkg.
module sotp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [15:0]       srv_id,
    input  logic [15:0]       meth_id,
    input  logic [15:0]       clnt_id,
    input  logic [15:0]       sess_id,
    input  logic [7:0]        proto_version,
    input  logic [7:0]        iface_version,
    input  logic [7:0]        msg_type,
    input  logic [7:0]        return_code,
    input  logic [31:0]       payload_length,
    input  logic              e2e_present,
    input  logic [7:0]        data_byte,
    input  logic              q_full,
    output logic              push,
    output sotp_pkg::job_t    job
);

    logic [31:0] max_msg_reg, max_seg_reg;
    logic        in_message_reg, in_message_next;
    logic        tp_mode_reg, tp_mode_next;
    logic [63:0] h0_reg, h0_next;
    logic [31:0] h1_reg, h1_next;
    logic [31:0] bytes_seen_reg, bytes_seen_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [15:0] seg_left_reg, seg_left_next;
    logic [15:0] seg_cap_reg, seg_cap_next;
    logic [7:0]  seq_counter_reg, seq_counter_next;
    logic [7:0]  cur_seq_reg, cur_seq_next;
    logic [31:0] cur_off_reg, cur_off_next;
    logic [1:0]  cur_type_reg, cur_type_next;

    logic        accept;
    logic [31:0] uni, start_size, bs_inc, rem_dec, nxt_size;
    logic [15:0] sl_dec;
    logic        start_more, seg_refuse, nxt_more, done, seg_end;
    logic [63:0] hdr0;
    logic [31:0] hdr1_plain, hdr1_tp;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign uni        = {max_seg_reg[31:4], 4'h0};
    assign start_more = payload_length > uni;
    assign start_size = start_more ? uni : payload_length;
    assign seg_refuse = e2e_present || (max_seg_reg > sotp_pkg::SEG_SIZE_MAX)
                        || (max_seg_reg[31:4] == 28'd0);
    assign hdr0       = {srv_id, meth_id, clnt_id, sess_id};
    assign hdr1_plain = {proto_version, iface_version, msg_type, return_code};
    assign hdr1_tp    = {proto_version, iface_version, msg_type | sotp_pkg::TP_FLAG,
                         return_code};

    assign bs_inc   = bytes_seen_reg + 32'd1;
    assign rem_dec  = remaining_reg - 32'd1;
    assign sl_dec   = seg_left_reg - 16'd1;
    assign done     = rem_dec == 32'd0;
    assign seg_end  = sl_dec == 16'd0;
    assign nxt_more = rem_dec > {16'd0, seg_cap_reg};
    assign nxt_size = nxt_more ? {16'd0, seg_cap_reg} : rem_dec;

    always_comb
    begin
        in_message_next  = in_message_reg;
        tp_mode_next     = tp_mode_reg;
        h0_next          = h0_reg;
        h1_next          = h1_reg;
        bytes_seen_next  = bytes_seen_reg;
        remaining_next   = remaining_reg;
        seg_left_next    = seg_left_reg;
        seg_cap_next     = seg_cap_reg;
        seq_counter_next = seq_counter_reg;
        cur_seq_next     = cur_seq_reg;
        cur_off_next     = cur_off_reg;
        cur_type_next    = cur_type_reg;
        push             = 1'b0;
        job              = '0;
        job.jk           = sotp_pkg::JOB_STATUS;
        job.stat         = sotp_pkg::STAT_OK;
        job.seq          = cur_seq_reg;
        job.h0           = h0_reg;
        job.h1           = h1_reg;
        job.htp          = 1'b1;
        job.dbyte        = data_byte;
        job.byte_type    = cur_type_reg;
        job.byte_off     = cur_off_reg;
        if (accept)
        begin
            if (cmd == sotp_pkg::CMD_START)
            begin
                in_message_next = 1'b0;
                tp_mode_next    = 1'b0;
                bytes_seen_next = 32'd0;
                remaining_next  = payload_length;
                seg_left_next   = 16'd0;
                cur_off_next    = 32'd0;
                cur_type_next   = sotp_pkg::SEG_SINGLE;
                push            = 1'b1;
                if (payload_length > max_msg_reg)
                begin
                    job.stat = sotp_pkg::STAT_TOO_LARGE;
                end
                else if (payload_length <= max_seg_reg)
                begin
                    if (payload_length > sotp_pkg::SINGLE_LEN_MAX)
                    begin
                        job.stat = sotp_pkg::STAT_SEG_FAIL;
                    end
                    else
                    begin
                        h0_next          = hdr0;
                        h1_next          = hdr1_plain;
                        cur_seq_next     = seq_counter_reg;
                        seq_counter_next = seq_counter_reg + 8'd1;
                        in_message_next  = payload_length != 32'd0;
                        job.jk    = sotp_pkg::JOB_HDR;
                        job.seq   = seq_counter_reg;
                        job.h0    = hdr0;
                        job.h1    = hdr1_plain;
                        job.hlen  = payload_length + sotp_pkg::LEN_ADD_PLAIN;
                        job.hword = 32'd0;
                        job.htp   = 1'b0;
                        job.heos  = payload_length == 32'd0;
                        job.htype = sotp_pkg::SEG_SINGLE;
                        job.hoff  = 32'd0;
                    end
                end
                else if (seg_refuse)
                begin
                    job.stat = sotp_pkg::STAT_SEG_FAIL;
                end
                else
                begin
                    h0_next          = hdr0;
                    h1_next          = hdr1_tp;
                    cur_seq_next     = seq_counter_reg;
                    seq_counter_next = seq_counter_reg + 8'd1;
                    seg_cap_next     = uni[15:0];
                    tp_mode_next     = 1'b1;
                    in_message_next  = 1'b1;
                    cur_type_next    = sotp_pkg::SEG_FIRST;
                    seg_left_next    = start_size[15:0];
                    job.jk    = sotp_pkg::JOB_HDR;
                    job.seq   = seq_counter_reg;
                    job.h0    = hdr0;
                    job.h1    = hdr1_tp;
                    job.hlen  = start_size + sotp_pkg::LEN_ADD_TP;
                    job.hword = {31'd0, start_more};
                    job.htp   = 1'b1;
                    job.heos  = 1'b0;
                    job.htype = sotp_pkg::SEG_FIRST;
                    job.hoff  = 32'd0;
                end
            end
            else if (in_message_reg)
            begin
                push            = 1'b1;
                bytes_seen_next = bs_inc;
                remaining_next  = rem_dec;
                job.jk          = sotp_pkg::JOB_BYTE;
                if (tp_mode_reg)
                begin
                    seg_left_next = sl_dec;
                    job.byte_eos  = seg_end || done;
                    if (done)
                    begin
                        in_message_next = 1'b0;
                    end
                    else if (seg_end)
                    begin
                        cur_off_next  = bs_inc;
                        cur_type_next = nxt_more ? sotp_pkg::SEG_CONSECUTIVE
                                                 : sotp_pkg::SEG_LAST;
                        seg_left_next = nxt_size[15:0];
                        job.jk    = sotp_pkg::JOB_BYTE_HDR;
                        job.hlen  = nxt_size + sotp_pkg::LEN_ADD_TP;
                        job.hword = {bs_inc[31:4], 3'b000, nxt_more};
                        job.htp   = 1'b1;
                        job.heos  = 1'b0;
                        job.htype = nxt_more ? sotp_pkg::SEG_CONSECUTIVE
                                             : sotp_pkg::SEG_LAST;
                        job.hoff  = bs_inc;
                    end
                end
                else
                begin
                    job.byte_eos = done;
                    if (done)
                    begin
                        in_message_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_msg_reg     <= sotp_pkg::MAX_MSG_RST;
            max_seg_reg     <= sotp_pkg::MAX_SEG_RST;
            in_message_reg  <= 1'b0;
            tp_mode_reg     <= 1'b0;
            h0_reg          <= 64'd0;
            h1_reg          <= 32'd0;
            bytes_seen_reg  <= 32'd0;
            remaining_reg   <= 32'd0;
            seg_left_reg    <= 16'd0;
            seg_cap_reg     <= 16'd0;
            seq_counter_reg <= 8'd0;
            cur_seq_reg     <= 8'd0;
            cur_off_reg     <= 32'd0;
            cur_type_reg    <= sotp_pkg::SEG_SINGLE;
        end
        else
        begin
            if (cfg_we && cfg_index == sotp_pkg::CFG_MAX_MSG)
            begin
                max_msg_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == sotp_pkg::CFG_MAX_SEG)
            begin
                max_seg_reg <= cfg_data;
            end
            in_message_reg  <= in_message_next;
            tp_mode_reg     <= tp_mode_next;
            h0_reg          <= h0_next;
            h1_reg          <= h1_next;
            bytes_seen_reg  <= bytes_seen_next;
            remaining_reg   <= remaining_next;
            seg_left_reg    <= seg_left_next;
            seg_cap_reg     <= seg_cap_next;
            seq_counter_reg <= seq_counter_next;
            cur_seq_reg     <= cur_seq_next;
            cur_off_reg     <= cur_off_next;
            cur_type_reg    <= cur_type_next;
        end
    end

endmodule

>>> src/sotp_jobq.sv
// sotp_jobq: small FIFO of jobs between the front and back parts.
// Depends on sotp_pkg for the job type.
module sotp_jobq #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sotp_pkg::job_t din,
    input  logic           pop,
    output sotp_pkg::job_t dout,
    output logic           full,
    output logic           empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    sotp_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full    = count_reg == CNT_FULL;
    assign empty   = count_reg == '0;
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

>>> src/sotp_back.sv
// sotp_back: expands the job at the head of the queue into result transfers
// (status, header bytes, payload byte) through an output register. Depends on sotp_pkg.
module sotp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sotp_pkg::job_t job,
    input  logic           job_valid,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output sotp_pkg::res_t res
);

    function automatic logic [7:0] hdr_byte(sotp_pkg::job_t j, logic [4:0] i);
        logic [7:0] b;
        case (i)
            5'd0:    b = j.h0[63:56];
            5'd1:    b = j.h0[55:48];
            5'd2:    b = j.h0[47:40];
            5'd3:    b = j.h0[39:32];
            5'd4:    b = j.hlen[31:24];
            5'd5:    b = j.hlen[23:16];
            5'd6:    b = j.hlen[15:8];
            5'd7:    b = j.hlen[7:0];
            5'd8:    b = j.h0[31:24];
            5'd9:    b = j.h0[23:16];
            5'd10:   b = j.h0[15:8];
            5'd11:   b = j.h0[7:0];
            5'd12:   b = j.h1[31:24];
            5'd13:   b = j.h1[23:16];
            5'd14:   b = j.h1[15:8];
            5'd15:   b = j.h1[7:0];
            5'd16:   b = j.hword[31:24];
            5'd17:   b = j.hword[23:16];
            5'd18:   b = j.hword[15:8];
            5'd19:   b = j.hword[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    logic [4:0]     idx_reg;
    logic           out_valid_reg;
    sotp_pkg::res_t res_reg, cur;
    logic [4:0]     hidx, hlast;
    logic           adv, fire;

    assign adv   = !out_valid_reg || out_ready;
    assign fire  = adv && job_valid;
    assign hlast = job.htp ? (sotp_pkg::TP_HDR_BYTES - 5'd1) : (sotp_pkg::HDR_BYTES - 5'd1);
    assign hidx  = (job.jk == sotp_pkg::JOB_BYTE_HDR) ? idx_reg - 5'd1 : idx_reg;

    always_comb
    begin
        cur                = '0;
        cur.kind           = sotp_pkg::KIND_HDR;
        cur.status         = sotp_pkg::STAT_OK;
        cur.out_byte       = hdr_byte(job, hidx);
        cur.seg_type       = job.htype;
        cur.seg_offset     = job.hoff;
        cur.seq_number     = job.seq;
        cur.last           = hidx == hlast;
        cur.end_of_segment = job.heos && (hidx == hlast);
        case (job.jk)
            sotp_pkg::JOB_STATUS:
            begin
                cur                = '0;
                cur.kind           = sotp_pkg::KIND_STATUS;
                cur.status         = job.stat;
                cur.last           = 1'b1;
            end
            sotp_pkg::JOB_HDR:
            begin
            end
            sotp_pkg::JOB_BYTE, sotp_pkg::JOB_BYTE_HDR:
            begin
                if (job.jk == sotp_pkg::JOB_BYTE || idx_reg == 5'd0)
                begin
                    cur.kind           = sotp_pkg::KIND_PAYLOAD;
                    cur.out_byte       = job.dbyte;
                    cur.seg_type       = job.byte_type;
                    cur.seg_offset     = job.byte_off;
                    cur.end_of_segment = job.byte_eos;
                    cur.last           = job.jk == sotp_pkg::JOB_BYTE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign pop       = fire && cur.last;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 5'd0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= job_valid;
            end
            if (fire)
            begin
                idx_reg <= cur.last ? 5'd0 : idx_reg + 5'd1;
            end
        end
    end

endmodule

>>> src/someip_tp_segmenter.sv
// Top level of the SOME/IP-TP segmenter: front classifier, job queue, result sequencer.
// Depends on sotp_pkg, sotp_front, sotp_jobq and sotp_back.
//
// While the output is not stalled, a stream of payload bytes passes at one transfer per
// cycle. A start transfer yields a 16-byte header (single message), a 20-byte segment
// header or a status transfer; a byte that closes a non-final segment yields 21 output
// transfers, sent one per cycle while out_ready holds by the result sequencer that sets
// the output rate. The input is held off only while the job queue (QUEUE_DEPTH jobs) is
// full. Configuration writes take effect at once and no clearing pass follows reset.
module someip_tp_segmenter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [15:0] srv_id,
    input  logic [15:0] meth_id,
    input  logic [15:0] clnt_id,
    input  logic [15:0] sess_id,
    input  logic [7:0]  proto_version,
    input  logic [7:0]  iface_version,
    input  logic [7:0]  msg_type,
    input  logic [7:0]  return_code,
    input  logic [31:0] payload_length,
    input  logic        e2e_present,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  seg_type,
    output logic [31:0] seg_offset,
    output logic [7:0]  seq_number,
    output logic        end_of_segment,
    output logic [1:0]  status,
    output logic        last
);

    sotp_pkg::job_t q_in, q_out;
    sotp_pkg::res_t res;
    logic           q_push, q_pop, q_full, q_empty;

    sotp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .srv_id         (srv_id),
        .meth_id        (meth_id),
        .clnt_id        (clnt_id),
        .sess_id        (sess_id),
        .proto_version  (proto_version),
        .iface_version  (iface_version),
        .msg_type       (msg_type),
        .return_code    (return_code),
        .payload_length (payload_length),
        .e2e_present    (e2e_present),
        .data_byte      (data_byte),
        .q_full         (q_full),
        .push           (q_push),
        .job            (q_in)
    );

    sotp_jobq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .pop   (q_pop),
        .dout  (q_out),
        .full  (q_full),
        .empty (q_empty)
    );

    sotp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_out),
        .job_valid (!q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign kind           = res.kind;
    assign out_byte       = res.out_byte;
    assign seg_type       = res.seg_type;
    assign seg_offset     = res.seg_offset;
    assign seq_number     = res.seq_number;
    assign end_of_segment = res.end_of_segment;
    assign status         = res.status;
    assign last           = res.last;

endmodule

>>> src/sotp_checker.sv
// sotp_checker: port-level assertions for someip_tp_segmenter, with its bind.
// Depends on sotp_pkg and the top level's ports.
module sotp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  out_byte,
    input logic [1:0]  seg_type,
    input logic [31:0] seg_offset,
    input logic [7:0]  seq_number,
    input logic        end_of_segment,
    input logic [1:0]  status,
    input logic        last
);

    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == sotp_pkg::KIND_STATUS |->
            last && out_byte == 8'd0 && seq_number == 8'd0 && !end_of_segment
            && seg_offset == 32'd0 && seg_type == sotp_pkg::SEG_SINGLE)
        else $error("status transfer carries byte fields");

    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != sotp_pkg::KIND_STATUS |->
            status == sotp_pkg::STAT_OK && kind != 2'd3)
        else $error("byte transfer with bad kind or status");

    a_single_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != sotp_pkg::KIND_STATUS && seg_type == sotp_pkg::SEG_SINGLE
            |-> seg_offset == 32'd0)
        else $error("single message with nonzero offset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
            && $stable(last))
        else $error("stalled output changed");

endmodule

bind someip_tp_segmenter sotp_checker u_sotp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .out_byte       (out_byte),
    .seg_type       (seg_type),
    .seg_offset     (seg_offset),
    .seq_number     (seq_number),
    .end_of_segment (end_of_segment),
    .status         (status),
    .last           (last)
);
